// ----- design/teletype_io_interface_core_defines.svh -----
// ----------------------------------------------------------------------------
// teletype interface assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TELETYPE_IO_INTERFACE_CORE_DEFINES_SVH
`define TELETYPE_IO_INTERFACE_CORE_DEFINES_SVH

// consequent checked in the same cycle
`define TTY_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked from the next cycle on
`define TTY_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/tty_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_pkg
// types and codes shared by the teletype interface modules
// ----------------------------------------------------------------------------
package tty_pkg;

  // bus operations
  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_CONTROL = 3'd1;
  localparam logic [2:0] OP_SKIP    = 3'd2;
  localparam logic [2:0] OP_WRITE   = 3'd3;
  localparam logic [2:0] OP_MASK    = 3'd4;
  localparam logic [2:0] OP_EVENT   = 3'd5;
  localparam logic [2:0] OP_CLEAR   = 3'd6;

  // function field, instruction bits 8..6
  localparam logic [2:0] FN_0000 = 3'o0;
  localparam logic [2:0] FN_0100 = 3'o1;
  localparam logic [2:0] FN_0200 = 3'o2;
  localparam logic [2:0] FN_0400 = 3'o4;
  localparam logic [2:0] FN_0500 = 3'o5;

  // input read codes, instruction bits 8..0
  localparam logic [8:0] RD_FULL = 9'o004;
  localparam logic [8:0] RD_LOW6 = 9'o204;

  localparam logic [6:0] STOP_CHAR = 7'o023;

  // activity state
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_DUMMY  = 2'd1;
  localparam logic [1:0] ACT_OUTPUT = 2'd2;
  localparam logic [1:0] ACT_INPUT  = 2'd3;

  // timer event reasons
  localparam logic [1:0] WHY_DUMMY  = 2'd0;
  localparam logic [1:0] WHY_OUTPUT = 2'd1;
  localparam logic [1:0] WHY_INPUT  = 2'd2;

  // interrupt actions
  localparam logic [1:0] IRQ_NONE  = 2'd0;
  localparam logic [1:0] IRQ_SET   = 2'd1;
  localparam logic [1:0] IRQ_CLEAR = 2'd2;

  // configuration register indexes
  localparam logic CFG_CHAR_TIME  = 1'b0;
  localparam logic CFG_DUMMY_TIME = 1'b1;

  localparam logic [15:0] CHAR_TIME_RST  = 16'd1145;
  localparam logic [15:0] DUMMY_TIME_RST = 16'd104;

  typedef struct packed {
    logic [2:0]  operation;
    logic [9:0]  instruction;
    logic [15:0] write_data;
    logic [1:0]  event_reason;
    logic        char_valid;
    logic [7:0]  char_value;
  } in_word_t;

  typedef struct packed {
    logic        ready_status;
    logic [15:0] read_data;
    logic [1:0]  irq_action;
    logic        irq_mask_bit;
    logic        sched_valid;
    logic [1:0]  sched_reason;
    logic [15:0] sched_delay;
    logic        punch_valid;
    logic [15:0] punch_data;
    logic        char_taken;
    logic        illegal;
  } out_word_t;

  typedef struct packed {
    logic [15:0] char_time_us;
    logic [15:0] dummy_time_us;
  } cfg_t;

endpackage

// ----- design/tty_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_cfg_regs
// character and dummy cycle delay registers behind the write port
// ----------------------------------------------------------------------------
module tty_cfg_regs import tty_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  output cfg_t        cfg
);

  logic [15:0] char_time_r, char_time_nxt;
  logic [15:0] dummy_time_r, dummy_time_nxt;

  always_comb begin
    char_time_nxt  = char_time_r;
    dummy_time_nxt = dummy_time_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CHAR_TIME:  char_time_nxt  = cfg_wdata;
        CFG_DUMMY_TIME: dummy_time_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_time_r  <= CHAR_TIME_RST;
      dummy_time_r <= DUMMY_TIME_RST;
    end else begin
      char_time_r  <= char_time_nxt;
      dummy_time_r <= dummy_time_nxt;
    end
  end

  assign cfg.char_time_us  = char_time_r;
  assign cfg.dummy_time_us = dummy_time_r;

endmodule

// ----- design/tty_exec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tty_exec
// interface flags and buffer, one bus operation decoded and applied per cycle while exec_en is high
// ----------------------------------------------------------------------------
module tty_exec import tty_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      exec_en,
  input  in_word_t  item,
  input  cfg_t      cfg,
  output out_word_t res
);

  logic [15:0] buf_r, buf_nxt;
  logic        ready_r, ready_nxt;
  logic        in_wait_r, in_wait_nxt;
  logic        out_dir_r, out_dir_nxt;
  logic        out_wait_r, out_wait_nxt;
  logic [1:0]  act_r, act_nxt;
  logic        mask_r, mask_nxt;

  logic [2:0]  fn;
  logic [8:0]  rd_code;
  logic [15:0] wd;

  assign fn      = item.instruction[8:6];
  assign rd_code = item.instruction[8:0];
  assign wd      = item.write_data;

  always_comb begin
    buf_nxt      = buf_r;
    ready_nxt    = ready_r;
    in_wait_nxt  = in_wait_r;
    out_dir_nxt  = out_dir_r;
    out_wait_nxt = out_wait_r;
    act_nxt      = act_r;
    mask_nxt     = mask_r;
    res          = '0;

    case (item.operation)
      OP_READ: begin
        res.ready_status = ready_r;
        if (ready_r) begin
          if (rd_code == RD_FULL) begin
            res.read_data = buf_r;
          end else if (rd_code == RD_LOW6) begin
            res.read_data = {10'd0, buf_r[5:0]};
          end else begin
            res.illegal = 1'b1;
          end
          in_wait_nxt    = 1'b0;
          ready_nxt      = 1'b0;
          res.irq_action = IRQ_CLEAR;
        end else if (!in_wait_r && item.char_valid) begin
          buf_nxt          = {8'd0, item.char_value};
          act_nxt          = ACT_INPUT;
          in_wait_nxt      = 1'b1;
          res.char_taken   = 1'b1;
          res.sched_valid  = 1'b1;
          res.sched_reason = WHY_INPUT;
          res.sched_delay  = cfg.char_time_us;
        end
      end
      OP_CONTROL: begin
        res.ready_status = 1'b1;
        if (fn == FN_0000) begin
          out_dir_nxt    = 1'b0;
          act_nxt        = ACT_NONE;
          ready_nxt      = 1'b0;
          res.irq_action = IRQ_CLEAR;
        end else if (fn == FN_0100) begin
          out_dir_nxt      = 1'b1;
          act_nxt          = ACT_DUMMY;
          ready_nxt        = 1'b1;
          res.irq_action   = IRQ_SET;
          res.sched_valid  = 1'b1;
          res.sched_reason = WHY_DUMMY;
          res.sched_delay  = cfg.dummy_time_us;
        end else begin
          res.illegal = 1'b1;
        end
      end
      OP_SKIP: begin
        case (fn)
          FN_0000: res.ready_status = ready_r;
          FN_0100: res.ready_status = (act_r == ACT_NONE);
          FN_0400: res.ready_status = !(ready_r && mask_r);
          FN_0500: res.ready_status = !out_dir_r && ready_r && (buf_r[6:0] == STOP_CHAR);
          default: res.illegal = 1'b1;
        endcase
      end
      OP_WRITE: begin
        res.ready_status = ready_r;
        if (ready_r) begin
          if (fn == FN_0000) begin
            buf_nxt = wd;
          end else if (fn == FN_0200) begin
            buf_nxt = {8'd0, wd[7], ~wd[5], wd[5:0]};
          end else begin
            res.illegal = 1'b1;
          end
          ready_nxt      = 1'b0;
          res.irq_action = IRQ_CLEAR;
          if (act_r == ACT_DUMMY) begin
            out_wait_nxt = 1'b1;
          end else begin
            act_nxt          = ACT_OUTPUT;
            res.sched_valid  = 1'b1;
            res.sched_reason = WHY_OUTPUT;
            res.sched_delay  = cfg.char_time_us;
          end
        end
      end
      OP_MASK: begin
        res.ready_status = 1'b1;
        mask_nxt         = wd[5];
        res.irq_action   = (ready_r && wd[5]) ? IRQ_SET : IRQ_CLEAR;
      end
      OP_EVENT: begin
        case (item.event_reason)
          WHY_DUMMY: begin
            if (act_r == ACT_DUMMY) begin
              if (out_wait_r) begin
                act_nxt          = ACT_OUTPUT;
                out_wait_nxt     = 1'b0;
                res.sched_valid  = 1'b1;
                res.sched_reason = WHY_OUTPUT;
                res.sched_delay  = cfg.char_time_us;
              end else begin
                act_nxt = ACT_NONE;
              end
            end
          end
          WHY_OUTPUT: begin
            if (act_r == ACT_OUTPUT) begin
              act_nxt         = ACT_NONE;
              ready_nxt       = 1'b1;
              res.irq_action  = IRQ_SET;
              res.punch_valid = 1'b1;
              res.punch_data  = buf_r;
            end
          end
          WHY_INPUT: begin
            if (act_r == ACT_INPUT) begin
              act_nxt        = ACT_NONE;
              in_wait_nxt    = 1'b0;
              ready_nxt      = 1'b1;
              res.irq_action = IRQ_SET;
            end
          end
          default: res.illegal = 1'b1;
        endcase
      end
      OP_CLEAR: begin
        buf_nxt      = '0;
        ready_nxt    = 1'b0;
        in_wait_nxt  = 1'b0;
        out_dir_nxt  = 1'b0;
        out_wait_nxt = 1'b0;
        act_nxt      = ACT_NONE;
        mask_nxt     = 1'b0;
      end
      default: res.illegal = 1'b1;
    endcase

    res.irq_mask_bit = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r      <= '0;
      ready_r    <= 1'b0;
      in_wait_r  <= 1'b0;
      out_dir_r  <= 1'b0;
      out_wait_r <= 1'b0;
      act_r      <= ACT_NONE;
      mask_r     <= 1'b0;
    end else if (exec_en) begin
      buf_r      <= buf_nxt;
      ready_r    <= ready_nxt;
      in_wait_r  <= in_wait_nxt;
      out_dir_r  <= out_dir_nxt;
      out_wait_r <= out_wait_nxt;
      act_r      <= act_nxt;
      mask_r     <= mask_nxt;
    end
  end

endmodule

// ----- design/teletype_io_interface_core.sv -----
`timescale 1ns / 1ps
// a word taken into the input register shows on out_word with out_strobe from the result register
// throughput: one word per cycle; busy stays low, one input register and one result register
// rate is set by the single decode and update pass through the flag and buffer registers
// reset (rst_n low, synchronous) clears all flags, the buffer, the mask and both strobes
// and restores the character and dummy cycle delays to their defaults
// ----------------------------------------------------------------------------
// teletype_io_interface_core
// teletype interface on a 16-bit minicomputer i/o bus, top level
// ----------------------------------------------------------------------------
`include "teletype_io_interface_core_defines.svh"

module teletype_io_interface_core import tty_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_strobe,
  output out_word_t   out_word,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic      in_vld_r;
  in_word_t  in_word_r;
  logic      out_strobe_r;
  out_word_t out_word_r;
  out_word_t res;
  cfg_t      cfg;

  assign busy = 1'b0;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_word_r <= in_word;
    end
  end

  tty_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tty_exec u_exec (
    .clk     (clk),
    .rst_n   (rst_n),
    .exec_en (in_vld_r),
    .item    (in_word_r),
    .cfg     (cfg),
    .res     (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_word_r <= res;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  `TTY_ASSERT_NEXT(a_word_to_strobe, start && !busy, ##1 out_strobe, "accepted word lost")
  `TTY_ASSERT_NOW(a_punch_irq, out_strobe && out_word.punch_valid, out_word.irq_action == IRQ_SET && !out_word.sched_valid, "punch without interrupt set")
  `TTY_ASSERT_NOW(a_char_sched, out_strobe && out_word.char_taken, out_word.sched_valid && out_word.sched_reason == WHY_INPUT && !out_word.ready_status, "taken character without input timer")

endmodule

// ----- dv/tb_teletype_io_interface_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_teletype_io_interface_core
// self-checking bench for the teletype bus interface: directed bus operations
// walk the input, output, skip, mask and illegal-code paths, then constrained
// random traffic runs under several delay settings; every result word is
// compared field by field with a behavioral mirror of the interface
// ----------------------------------------------------------------------------
module tb_teletype_io_interface_core;
  import tty_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [1:0] WHY_BAD   = 2'd3;
  localparam logic [8:0] RD_BAD    = 9'o777;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_word;
  logic        out_strobe;
  out_word_t   out_word;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;

  // mirror of the interface state
  logic [15:0] tty_buf;
  logic        tty_ready;
  logic        tty_in_wait;
  logic        tty_out_dir;
  logic        tty_out_wait;
  logic [1:0]  tty_act;
  logic        tty_mask;
  cfg_t        tty_cfg;

  out_word_t   expected_words[$];
  int          n_errors;
  int          n_sent;
  int          n_checked;
  int          n_settings;
  int          quiet_left;

  teletype_io_interface_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words outstanding", expected_words.size());
    $display("tb_teletype_io_interface_core: FAIL");
    $finish;
  end

  function automatic void clear_tty_state();
    tty_buf      = '0;
    tty_ready    = 1'b0;
    tty_in_wait  = 1'b0;
    tty_out_dir  = 1'b0;
    tty_out_wait = 1'b0;
    tty_act      = ACT_NONE;
    tty_mask     = 1'b0;
  endfunction

  function automatic out_word_t predict_tty(in_word_t w);
    out_word_t  r;
    logic [2:0] fn;
    r  = '0;
    fn = w.instruction[8:6];
    case (w.operation)
      OP_READ: begin
        r.ready_status = tty_ready;
        if (tty_ready) begin
          if (w.instruction[8:0] == RD_FULL) r.read_data = tty_buf;
          else if (w.instruction[8:0] == RD_LOW6) r.read_data = {10'd0, tty_buf[5:0]};
          else r.illegal = 1'b1;
          tty_in_wait  = 1'b0;
          tty_ready    = 1'b0;
          r.irq_action = IRQ_CLEAR;
        end else if (!tty_in_wait && w.char_valid) begin
          tty_buf        = {8'd0, w.char_value};
          tty_act        = ACT_INPUT;
          tty_in_wait    = 1'b1;
          r.char_taken   = 1'b1;
          r.sched_valid  = 1'b1;
          r.sched_reason = WHY_INPUT;
          r.sched_delay  = tty_cfg.char_time_us;
        end
      end
      OP_CONTROL: begin
        r.ready_status = 1'b1;
        case (fn)
          FN_0000: begin
            tty_out_dir  = 1'b0;
            tty_act      = ACT_NONE;
            tty_ready    = 1'b0;
            r.irq_action = IRQ_CLEAR;
          end
          FN_0100: begin
            tty_out_dir    = 1'b1;
            tty_act        = ACT_DUMMY;
            tty_ready      = 1'b1;
            r.irq_action   = IRQ_SET;
            r.sched_valid  = 1'b1;
            r.sched_reason = WHY_DUMMY;
            r.sched_delay  = tty_cfg.dummy_time_us;
          end
          default: r.illegal = 1'b1;
        endcase
      end
      OP_SKIP: begin
        case (fn)
          FN_0000: r.ready_status = tty_ready;
          FN_0100: r.ready_status = (tty_act == ACT_NONE);
          FN_0400: r.ready_status = !(tty_ready && tty_mask);
          FN_0500: r.ready_status = !tty_out_dir && tty_ready && (tty_buf[6:0] == STOP_CHAR);
          default: r.illegal = 1'b1;
        endcase
      end
      OP_WRITE: begin
        r.ready_status = tty_ready;
        if (tty_ready) begin
          if (fn == FN_0000) tty_buf = w.write_data;
          else if (fn == FN_0200)
            tty_buf = {8'd0, w.write_data[7], ~w.write_data[5], w.write_data[5:0]};
          else r.illegal = 1'b1;
          tty_ready    = 1'b0;
          r.irq_action = IRQ_CLEAR;
          if (tty_act == ACT_DUMMY) begin
            tty_out_wait = 1'b1;
          end else begin
            tty_act        = ACT_OUTPUT;
            r.sched_valid  = 1'b1;
            r.sched_reason = WHY_OUTPUT;
            r.sched_delay  = tty_cfg.char_time_us;
          end
        end
      end
      OP_MASK: begin
        r.ready_status = 1'b1;
        tty_mask       = w.write_data[5];
        r.irq_action   = (tty_ready && tty_mask) ? IRQ_SET : IRQ_CLEAR;
      end
      OP_EVENT: begin
        case (w.event_reason)
          WHY_DUMMY: begin
            if (tty_act == ACT_DUMMY) begin
              if (tty_out_wait) begin
                tty_act        = ACT_OUTPUT;
                tty_out_wait   = 1'b0;
                r.sched_valid  = 1'b1;
                r.sched_reason = WHY_OUTPUT;
                r.sched_delay  = tty_cfg.char_time_us;
              end else begin
                tty_act = ACT_NONE;
              end
            end
          end
          WHY_OUTPUT: begin
            if (tty_act == ACT_OUTPUT) begin
              tty_act       = ACT_NONE;
              tty_ready     = 1'b1;
              r.irq_action  = IRQ_SET;
              r.punch_valid = 1'b1;
              r.punch_data  = tty_buf;
            end
          end
          WHY_INPUT: begin
            if (tty_act == ACT_INPUT) begin
              tty_act      = ACT_NONE;
              tty_in_wait  = 1'b0;
              tty_ready    = 1'b1;
              r.irq_action = IRQ_SET;
            end
          end
          default: r.illegal = 1'b1;
        endcase
      end
      OP_CLEAR: clear_tty_state();
      default: r.illegal = 1'b1;
    endcase
    r.irq_mask_bit = tty_mask;
    return r;
  endfunction

  function automatic in_word_t mk_word(logic [2:0] op, logic [9:0] ins, logic [15:0] wd,
                                       logic [1:0] why, logic cv, logic [7:0] ch);
    in_word_t w;
    w.operation    = op;
    w.instruction  = ins;
    w.write_data   = wd;
    w.event_reason = why;
    w.char_valid   = cv;
    w.char_value   = ch;
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      quiet_left = $urandom_range(20, 40);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // bus operation mostly well formed, event reasons biased toward the one in flight
  function automatic in_word_t rand_word();
    in_word_t    w;
    int          r;
    logic        good;
    logic [63:0] rnd;
    rnd    = {$urandom, $urandom};
    w      = in_word_t'(rnd[$bits(in_word_t)-1:0]);
    good   = ($urandom_range(0, 9) != 0);
    w.char_valid = ($urandom_range(0, 9) < 7);
    r = $urandom_range(0, 99);
    if (r < 20) w.operation = OP_READ;
    else if (r < 32) w.operation = OP_CONTROL;
    else if (r < 44) w.operation = OP_SKIP;
    else if (r < 62) w.operation = OP_WRITE;
    else if (r < 70) w.operation = OP_MASK;
    else if (r < 95) w.operation = OP_EVENT;
    else if (r < 98) w.operation = OP_CLEAR;
    else w.operation = OP_UNUSED;
    case (w.operation)
      OP_READ: if (good) w.instruction[8:0] = $urandom_range(0, 1) ? RD_FULL : RD_LOW6;
      OP_CONTROL: if (good) w.instruction[8:6] = $urandom_range(0, 1) ? FN_0000 : FN_0100;
      OP_SKIP: begin
        if (good) begin
          case ($urandom_range(0, 3))
            0: w.instruction[8:6] = FN_0000;
            1: w.instruction[8:6] = FN_0100;
            2: w.instruction[8:6] = FN_0400;
            default: w.instruction[8:6] = FN_0500;
          endcase
        end
      end
      OP_WRITE: if (good) w.instruction[8:6] = $urandom_range(0, 1) ? FN_0000 : FN_0200;
      OP_EVENT: begin
        if ($urandom_range(0, 99) < 65) begin
          case (tty_act)
            ACT_DUMMY: w.event_reason = WHY_DUMMY;
            ACT_OUTPUT: w.event_reason = WHY_OUTPUT;
            ACT_INPUT: w.event_reason = WHY_INPUT;
            default: w.event_reason = 2'($urandom_range(0, 2));
          endcase
        end else if (good) begin
          w.event_reason = 2'($urandom_range(0, 2));
        end
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) w.char_value[6:0] = STOP_CHAR;
    return w;
  endfunction

  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    expected_words.push_back(predict_tty(w));
    n_sent++;
  endtask

  task automatic drain_words();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == CFG_CHAR_TIME) tty_cfg.char_time_us = value;
    else tty_cfg.dummy_time_us = value;
  endtask

  task automatic check_field(input string name, input logic [15:0] exp,
                             input logic [15:0] act);
    if (act !== exp) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp, act);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe !== 1'b0) begin
      if (expected_words.size() == 0) begin
        $display("%0t ns: unexpected word, expected none, actual %h", $time, out_word);
        n_errors++;
      end else begin
        out_word_t e;
        e = expected_words.pop_front();
        n_checked++;
        check_field("ready_status", 16'(e.ready_status), 16'(out_word.ready_status));
        check_field("read_data",    e.read_data,         out_word.read_data);
        check_field("irq_action",   16'(e.irq_action),   16'(out_word.irq_action));
        check_field("irq_mask_bit", 16'(e.irq_mask_bit), 16'(out_word.irq_mask_bit));
        check_field("sched_valid",  16'(e.sched_valid),  16'(out_word.sched_valid));
        check_field("sched_reason", 16'(e.sched_reason), 16'(out_word.sched_reason));
        check_field("sched_delay",  e.sched_delay,       out_word.sched_delay);
        check_field("punch_valid",  16'(e.punch_valid),  16'(out_word.punch_valid));
        check_field("punch_data",   e.punch_data,        out_word.punch_data);
        check_field("char_taken",   16'(e.char_taken),   16'(out_word.char_taken));
        check_field("illegal",      16'(e.illegal),      16'(out_word.illegal));
      end
    end
  end

  task automatic test_input_path();
    send_word(mk_word(OP_READ, {1'b0, RD_FULL}, 16'h0000, WHY_DUMMY, 1'b1, 8'hff));
    send_word(mk_word(OP_READ, {1'b0, RD_FULL}, 16'h0000, WHY_DUMMY, 1'b1, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_INPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_READ, {1'b1, RD_FULL}, 16'hffff, WHY_BAD, 1'b1, 8'h00));
    send_word(mk_word(OP_READ, {1'b0, RD_FULL}, 16'h0000, WHY_DUMMY, 1'b1,
                      {1'b1, STOP_CHAR}));
    send_word(mk_word(OP_EVENT, 10'h3ff, 16'h0000, WHY_INPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_SKIP, {1'b0, FN_0500, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_READ, {1'b0, RD_LOW6}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_READ, {1'b0, RD_FULL}, 16'h0000, WHY_DUMMY, 1'b1, 8'h5a));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_INPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_READ, {1'b0, RD_BAD}, 16'h0000, WHY_DUMMY, 1'b1, 8'h00));
  endtask

  task automatic test_output_path();
    send_word(mk_word(OP_CONTROL, {1'b0, FN_0100, 6'o77}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_WRITE, {1'b0, FN_0000, 6'o00}, 16'hffff, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_OUTPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_OUTPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_WRITE, {1'b1, FN_0200, 6'o00}, 16'hff5f, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_OUTPUT, 1'b0, 8'h00));
    send_word(mk_word(OP_WRITE, {1'b0, FN_0400, 6'o00}, 16'h1234, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_CONTROL, {1'b0, FN_0000, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
  endtask

  task automatic test_skip_and_mask();
    send_word(mk_word(OP_CONTROL, {1'b0, FN_0100, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_MASK, 10'h000, 16'h0020, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_SKIP, {1'b0, FN_0400, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_SKIP, {1'b0, FN_0000, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_SKIP, {1'b0, FN_0100, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_SKIP, {1'b0, FN_0200, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_MASK, 10'h000, 16'hffdf, WHY_DUMMY, 1'b0, 8'h00));
  endtask

  task automatic test_illegal_and_clear();
    send_word(mk_word(OP_CONTROL, {1'b0, FN_0200, 6'o00}, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
    send_word(mk_word(OP_EVENT, 10'h000, 16'h0000, WHY_BAD, 1'b0, 8'h00));
    send_word(mk_word(OP_UNUSED, 10'h3ff, 16'hffff, WHY_BAD, 1'b1, 8'hff));
    send_word(mk_word(OP_CLEAR, 10'h000, 16'h0000, WHY_DUMMY, 1'b0, 8'h00));
  endtask

  task automatic test_random_traffic(input int n_words);
    repeat (n_words) send_word(rand_word());
  endtask

  initial begin
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= CFG_CHAR_TIME;
    cfg_wdata  <= '0;
    n_errors   = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_settings = 1;
    quiet_left = 0;
    clear_tty_state();
    tty_cfg.char_time_us  = CHAR_TIME_RST;
    tty_cfg.dummy_time_us = DUMMY_TIME_RST;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_input_path();
    test_output_path();
    test_skip_and_mask();
    test_illegal_and_clear();
    test_random_traffic(100);

    drain_words();
    write_cfg(CFG_CHAR_TIME, 16'h0000);
    write_cfg(CFG_DUMMY_TIME, 16'hffff);
    n_settings++;
    test_random_traffic(105);

    drain_words();
    write_cfg(CFG_CHAR_TIME, 16'hffff);
    write_cfg(CFG_DUMMY_TIME, 16'h0000);
    n_settings++;
    test_random_traffic(105);

    drain_words();
    write_cfg(CFG_CHAR_TIME, 16'($urandom_range(0, 65535)));
    write_cfg(CFG_DUMMY_TIME, 16'($urandom_range(0, 65535)));
    n_settings++;
    test_random_traffic(110);

    start <= 1'b0;
    repeat (1000) begin
      if (expected_words.size() != 0) @(posedge clk);
    end
    repeat (4) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t ns: %0d expected words never arrived", $time, expected_words.size());
      n_errors++;
    end

    $display("sent %0d bus operations (directed and random) under %0d delay settings",
             n_sent, n_settings);
    $display("compared %0d result words, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_teletype_io_interface_core: PASS");
    end else begin
      $display("tb_teletype_io_interface_core: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/tty_pkg.sv
design/tty_cfg_regs.sv
design/tty_exec.sv
design/teletype_io_interface_core.sv
dv/tb_teletype_io_interface_core.sv
